// File: design/lbmt_pkg.sv
// ----------------------------------------------------------------------------
// lbmt_pkg
// shared types and constants of the learning bridge mac table
// ----------------------------------------------------------------------------
package lbmt_pkg;

  localparam int unsigned TableEntries = 32;
  localparam int unsigned PortCount    = 16;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned CntW         = 6;
  localparam int unsigned MacW         = 48;
  localparam int unsigned PortW        = 4;
  localparam int unsigned MaskW        = 16;
  localparam int unsigned StampW       = 32;

  localparam logic [MacW-1:0]  MacBcast     = '1;
  localparam logic [StampW-1:0] MaxAgeReset = 32'd30000;
  localparam logic [MaskW-1:0] PortsReset   = 16'hFFFF;
  localparam logic [MaskW-1:0] PortLimit    =
    (PortCount >= MaskW) ? '1 : MaskW'((32'd1 << PortCount) - 32'd1);

  localparam logic [1:0] FuncFrame  = 2'd0;
  localparam logic [1:0] FuncSweep  = 2'd1;
  localparam logic [1:0] FuncRemove = 2'd2;
  localparam logic [1:0] FuncTick   = 2'd3;

  localparam logic [1:0] LearnKnown   = 2'd0;
  localparam logic [1:0] LearnRefresh = 2'd1;
  localparam logic [1:0] LearnNew     = 2'd2;
  localparam logic [1:0] LearnFull    = 2'd3;

  localparam logic CfgMaxAge = 1'b0;
  localparam logic CfgPorts  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic release_out;
  } lbmt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } lbmt_sts_t;

endpackage

// File: design/lbmt_ctrl.sv
// ----------------------------------------------------------------------------
// lbmt_ctrl
// item sequencer: capture, compare and write back, hand off to output stage
// ----------------------------------------------------------------------------
module lbmt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                out_stall_i,
  input  lbmt_pkg::lbmt_sts_t sts_i,
  output lbmt_pkg::lbmt_cmd_t cmd_o
);
  import lbmt_pkg::*;

  typedef enum logic {StIdle, StExec} state_e;
  state_e state_q;
  logic   take;

  // one item in compare, output register must be free to accept it
  assign in_stall_o = (state_q != StIdle);
  assign take       = in_valid_i && (state_q == StIdle);

  always_comb begin
    cmd_o.capture     = take;
    cmd_o.execute     = (state_q == StExec) && !sts_i.out_busy;
    cmd_o.release_out = !out_stall_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      unique case (state_q)
        StIdle: if (take) state_q <= StExec;
        StExec: if (!sts_i.out_busy) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// File: design/lbmt_dp.sv
// ----------------------------------------------------------------------------
// lbmt_dp
// table registers, parallel compare, write back and output register
// ----------------------------------------------------------------------------
module lbmt_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lbmt_pkg::lbmt_cmd_t         cmd_i,
  output lbmt_pkg::lbmt_sts_t         sts_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic [1:0]                  func_i,
  input  logic [lbmt_pkg::MacW-1:0]   dest_mac_i,
  input  logic [lbmt_pkg::MacW-1:0]   source_mac_i,
  input  logic [lbmt_pkg::PortW-1:0]  port_number_i,
  output logic                        out_valid_o,
  output logic [lbmt_pkg::MaskW-1:0]  forward_mask_o,
  output logic [lbmt_pkg::PortW-1:0]  dest_port_o,
  output logic                        dest_found_o,
  output logic                        flood_o,
  output logic [1:0]                  learn_status_o,
  output logic [lbmt_pkg::CntW-1:0]   cleared_count_o
);
  import lbmt_pkg::*;

  localparam int unsigned NclrW = $clog2(TableEntries + 1);

  logic [TableEntries-1:0] valid_q;
  logic [MacW-1:0]   mac_q   [TableEntries];
  logic [PortW-1:0]  port_q  [TableEntries];
  logic [StampW-1:0] stamp_q [TableEntries];
  logic [StampW-1:0] time_q, max_age_q;
  logic [MaskW-1:0]  ports_q;

  logic [1:0]       func_q;
  logic [MacW-1:0]  dmac_q, smac_q;
  logic [PortW-1:0] pnum_q;
  logic             ovalid_q;

  logic [TableEntries-1:0] dhit, shit, known_v, port_v, age_v, freev;
  logic                    found, known, any_s, any_f;
  logic [IdxW-1:0]         didx, sidx, fidx;
  logic [PortW-1:0]        dport;
  logic [MaskW-1:0]        fwd;
  logic [1:0]              status;
  logic [CntW-1:0]         cleared;
  logic [NclrW-1:0]        nclr;

  always_comb begin
    found = 1'b0; any_s = 1'b0; any_f = 1'b0;
    didx = '0; sidx = '0; fidx = '0; nclr = '0;
    for (int i = 0; i < TableEntries; i++) begin
      dhit[i]    = valid_q[i] && (mac_q[i] == dmac_q);
      shit[i]    = (mac_q[i] == smac_q);
      known_v[i] = valid_q[i] && shit[i] && (port_q[i] == pnum_q);
      port_v[i]  = valid_q[i] && (port_q[i] == pnum_q);
      age_v[i]   = valid_q[i] && ((time_q - stamp_q[i]) > max_age_q);
      freev[i]   = !valid_q[i];
    end
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (dhit[i])  begin found = 1'b1; didx = IdxW'(i); end
      if (shit[i])  begin any_s = 1'b1; sidx = IdxW'(i); end
      if (freev[i]) begin any_f = 1'b1; fidx = IdxW'(i); end
    end
    known = |known_v;
    dport = found ? port_q[didx] : '0;
    if (func_q == FuncSweep) nclr = NclrW'($countones(age_v));
    else if (func_q == FuncRemove) nclr = NclrW'($countones(port_v));
    cleared = (nclr > 63) ? CntW'(63) : CntW'(nclr);
    if (dmac_q != MacBcast && found) fwd = MaskW'(1) << dport;
    else fwd = ports_q & ~(MaskW'(1) << pnum_q);
    fwd = fwd & PortLimit;
    if (known) status = LearnKnown;
    else if (any_s) status = LearnRefresh;
    else if (any_f) status = LearnNew;
    else status = LearnFull;
  end

  assign sts_o.out_busy = ovalid_q && !cmd_i.release_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      time_q    <= '0;
      max_age_q <= MaxAgeReset;
      ports_q   <= PortsReset;
      ovalid_q  <= 1'b0;
      for (int i = 0; i < TableEntries; i++) begin
        mac_q[i] <= '0; port_q[i] <= '0; stamp_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i && cfg_index_i[1] == 1'b0) begin
        if (cfg_index_i[0] == CfgMaxAge) max_age_q <= cfg_data_i;
        else ports_q <= cfg_data_i[MaskW-1:0];
      end
      if (cmd_i.execute) ovalid_q <= 1'b1;
      else if (cmd_i.release_out) ovalid_q <= 1'b0;
      if (cmd_i.execute) begin
        case (func_q)
          FuncFrame: begin
            if (!known && any_s) begin
              valid_q[sidx] <= 1'b1; port_q[sidx] <= pnum_q; stamp_q[sidx] <= time_q;
            end else if (!known && any_f) begin
              valid_q[fidx] <= 1'b1; mac_q[fidx] <= smac_q;
              port_q[fidx] <= pnum_q; stamp_q[fidx] <= time_q;
            end
          end
          FuncSweep: begin
            for (int i = 0; i < TableEntries; i++) begin
              if (age_v[i]) begin
                valid_q[i] <= 1'b0; mac_q[i] <= '0; port_q[i] <= '0; stamp_q[i] <= '0;
              end
            end
          end
          FuncRemove: valid_q <= valid_q & ~port_v;
          default: time_q <= time_q + 1'b1;
        endcase
      end
    end
  end

  // captured item and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_i; dmac_q <= dest_mac_i; smac_q <= source_mac_i;
      pnum_q <= port_number_i;
    end
    if (cmd_i.execute) begin
      if (func_q == FuncFrame) begin
        forward_mask_o <= fwd; dest_port_o <= dport; dest_found_o <= found;
        flood_o <= !(dmac_q != MacBcast && found); learn_status_o <= status;
        cleared_count_o <= '0;
      end else begin
        forward_mask_o <= '0; dest_port_o <= '0; dest_found_o <= 1'b0;
        flood_o <= 1'b0; learn_status_o <= LearnKnown; cleared_count_o <= cleared;
      end
    end
  end

  assign out_valid_o = ovalid_q;
endmodule

// File: design/learning_bridge_mac_table.sv
// ----------------------------------------------------------------------------
// learning_bridge_mac_table
// learning ethernet bridge address table with lookup, learning and aging
// ----------------------------------------------------------------------------
// channel  signals                               direction
// in       in_valid_i / in_stall_o + fields      item into block
// out      out_valid_o / out_stall_i + fields    result item out
// cfg      cfg_valid_i / cfg_ready_o, index/data register write
//
// an item is captured, then all 32 entries are compared in parallel with
// write back into the result register
// reset clears the whole table and the tick counter and sets the registers to their defaults at once
// a stalled result holds the compare stage, which then stalls the input
module learning_bridge_mac_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [47:0] dest_mac_i,
  input  logic [47:0] source_mac_i,
  input  logic [3:0]  port_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] forward_mask_o,
  output logic [3:0]  dest_port_o,
  output logic        dest_found_o,
  output logic        flood_o,
  output logic [1:0]  learn_status_o,
  output logic [5:0]  cleared_count_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import lbmt_pkg::*;

  lbmt_cmd_t cmd;
  lbmt_sts_t sts;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  lbmt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  lbmt_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .cfg_we_i(cfg_valid_i), .cfg_index_i, .cfg_data_i,
    .func_i, .dest_mac_i, .source_mac_i, .port_number_i,
    .out_valid_o, .forward_mask_o, .dest_port_o, .dest_found_o, .flood_o,
    .learn_status_o, .cleared_count_o
  );
endmodule

// File: design/lbmt_checker.sv
// ----------------------------------------------------------------------------
// lbmt_checker
// port level checks of the bridge table
// ----------------------------------------------------------------------------
module lbmt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       dest_found_o,
  input logic       flood_o,
  input logic [5:0] cleared_count_o,
  input logic [1:0] learn_status_o
);
  import lbmt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
    $stable({dest_found_o, flood_o, cleared_count_o, learn_status_o}))
    else $error("stalled result changed");
  a_stall_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("no stall in compare");
  a_frame_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cleared_count_o != 6'd0 |-> !dest_found_o && !flood_o &&
    learn_status_o == LearnKnown) else $error("mixed result");
endmodule

bind learning_bridge_mac_table lbmt_checker u_lbmt_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .dest_found_o, .flood_o, .cleared_count_o, .learn_status_o
);

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives frames, sweeps, port removals and ticks into the bridge table,
// predicts every result with a local copy of the table and checks each field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lbmt_pkg::*;

  localparam int unsigned NumSlots = 32;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = FuncTick;
  logic [47:0] dest_mac_i = '0;
  logic [47:0] source_mac_i = '0;
  logic [3:0]  port_number_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] forward_mask_o;
  logic [3:0]  dest_port_o;
  logic        dest_found_o;
  logic        flood_o;
  logic [1:0]  learn_status_o;
  logic [5:0]  cleared_count_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  learning_bridge_mac_table u_top (.*);

  always #5 clk_i = ~clk_i;

  // one result item as the block reports it
  typedef struct packed {
    logic [15:0] mask;
    logic [3:0]  port;
    logic        found;
    logic        flood;
    logic [1:0]  status;
    logic [5:0]  cleared;
  } fwd_result_t;

  // local copy of the address table
  logic        tbl_valid [NumSlots];
  logic [47:0] tbl_mac   [NumSlots];
  logic [3:0]  tbl_port  [NumSlots];
  logic [31:0] tbl_stamp [NumSlots];
  logic [31:0] tick_count;
  logic [31:0] age_limit;
  logic [15:0] port_enables;

  fwd_result_t pending_results[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_cycles = 0;

  // pool of addresses so lookups and learning hit often
  logic [47:0] mac_pool[16];

  // compute the result of one item and update the table copy
  function automatic fwd_result_t bridge_predict(logic [1:0] op, logic [47:0] dmac,
                                                 logic [47:0] smac, logic [3:0] pnum);
    fwd_result_t r;
    bit known;
    int hit, free_slot, cnt;
    r = '0;
    known = 0;
    hit = -1;
    free_slot = -1;
    cnt = 0;
    case (op)
      FuncFrame: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (tbl_valid[i]) begin
            if (!r.found && tbl_mac[i] == dmac) begin
              r.found = 1'b1;
              r.port = tbl_port[i];
            end
            if (tbl_mac[i] == smac && tbl_port[i] == pnum) known = 1;
          end
        end
        if (dmac != MacBcast && r.found) begin
          r.mask = 16'd1 << r.port;
        end else begin
          r.flood = 1'b1;
          r.mask = port_enables & ~(16'd1 << pnum);
        end
        r.mask &= PortLimit;
        r.status = LearnKnown;
        if (!known) begin
          for (int i = 0; i < NumSlots; i++) begin
            if (hit < 0 && tbl_mac[i] == smac) hit = i;
            if (free_slot < 0 && !tbl_valid[i]) free_slot = i;
          end
          if (hit >= 0) begin
            tbl_valid[hit] = 1'b1;
            tbl_port[hit] = pnum;
            tbl_stamp[hit] = tick_count;
            r.status = LearnRefresh;
          end else if (free_slot >= 0) begin
            tbl_valid[free_slot] = 1'b1;
            tbl_mac[free_slot] = smac;
            tbl_port[free_slot] = pnum;
            tbl_stamp[free_slot] = tick_count;
            r.status = LearnNew;
          end else begin
            r.status = LearnFull;
          end
        end
      end
      FuncSweep: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (tbl_valid[i] && (tick_count - tbl_stamp[i]) > age_limit) begin
            tbl_valid[i] = 1'b0;
            tbl_mac[i] = '0;
            tbl_port[i] = '0;
            tbl_stamp[i] = '0;
            cnt++;
          end
        end
        r.cleared = 6'(cnt);
      end
      FuncRemove: begin
        for (int i = 0; i < NumSlots; i++) begin
          if (tbl_valid[i] && tbl_port[i] == pnum) begin
            tbl_valid[i] = 1'b0;
            cnt++;
          end
        end
        r.cleared = 6'(cnt);
      end
      default: tick_count = tick_count + 32'd1;
    endcase
    return r;
  endfunction

  // send one item, predicting its result at acceptance; valid stays high
  // so the next item can follow at once
  task automatic send_item(logic [1:0] op, logic [47:0] dmac, logic [47:0] smac,
                           logic [3:0] pnum);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= op;
    dest_mac_i <= dmac;
    source_mac_i <= smac;
    port_number_i <= pnum;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(bridge_predict(op, dmac, smac, pnum));
    items_sent++;
  endtask

  // register write between phases, block idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == 2'(CfgMaxAge)) age_limit = val;
    else if (idx == 2'(CfgPorts)) port_enables = val[15:0];
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // receiver stall: random, or a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= (recv_stall_pct > 0) && ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    fwd_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {forward_mask_o, dest_port_o, dest_found_o, flood_o, learn_status_o,
             cleared_count_o};
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: mask %h/%h port %0d/%0d found %b/%b flood %b/%b",
                      " status %0d/%0d cleared %0d/%0d"},
                     want.mask, got.mask, want.port, got.port, want.found, got.found,
                     want.flood, got.flood, want.status, got.status,
                     want.cleared, got.cleared);
        end
      end
    end
  end

  function automatic logic [47:0] pick_mac();
    case ($urandom_range(9, 0))
      0: return MacBcast;
      1: return 48'({$urandom(), $urandom()});
      default: return mac_pool[$urandom_range(15, 0)];
    endcase
  endfunction

  // extremes of fields, every operation, special cases
  task automatic test_directed();
    send_item(FuncFrame, 48'h0, 48'h0, 4'd0);                    // zero mac learned
    send_item(FuncFrame, 48'h0, 48'h0, 4'd0);                    // known pair
    send_item(FuncFrame, 48'h0, 48'hFFFF_FFFF_FFFF, 4'd15);      // unicast, learn bcast src
    send_item(FuncFrame, MacBcast, 48'h1, 4'd15);                // broadcast floods
    send_item(FuncFrame, 48'h1, 48'h1, 4'd15);                   // unicast back to ingress
    send_item(FuncFrame, 48'h2, 48'h1, 4'd3);                    // moved, unknown dest
    send_item(FuncRemove, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'd3);
    send_item(FuncFrame, 48'h1, 48'h1, 4'd7);                    // refresh invalid slot
    send_item(FuncRemove, '0, '0, 4'd9);                         // nothing cleared
    send_item(FuncTick, '0, '0, '0);
    send_item(FuncTick, '0, '0, '0);
    send_item(FuncSweep, '0, '0, '0);                            // ages below limit
    write_reg(2'(CfgMaxAge), 32'd0);                             // purge nonzero ages
    send_item(FuncFrame, 48'h5, 48'h5, 4'd5);
    send_item(FuncSweep, '0, '0, '0);
    write_reg(2'(CfgPorts), 32'h0);
    send_item(FuncFrame, 48'h77, 48'h6, 4'd2);                   // empty flood mask
    write_reg(2'(CfgPorts), 32'hA5A5);
    send_item(FuncFrame, MacBcast, 48'h8, 4'd0);
    write_reg(2'd2, 32'hFFFF_FFFF);                              // index beyond registers
    write_reg(2'd3, 32'h0);
    // fill the table to full
    for (int i = 0; i < NumSlots + 2; i++)
      send_item(FuncFrame, 48'h5, 48'h1000 + i, 4'(i));
    write_reg(2'(CfgMaxAge), 32'hFFFF_FFFF);
    send_item(FuncSweep, '0, '0, '0);
    write_reg(2'(CfgMaxAge), 32'd1);
    send_item(FuncTick, '0, '0, '0);
    send_item(FuncTick, '0, '0, '0);
    send_item(FuncSweep, '0, '0, '0);                            // clear them all
  endtask

  task automatic test_random(int n);
    int op_roll;
    for (int k = 0; k < n; k++) begin
      op_roll = $urandom_range(99, 0);
      if (op_roll < 70) send_item(FuncFrame, pick_mac(), pick_mac(), 4'($urandom()));
      else if (op_roll < 76) send_item(FuncSweep, pick_mac(), pick_mac(), 4'($urandom()));
      else if (op_roll < 82) send_item(FuncRemove, pick_mac(), pick_mac(), 4'($urandom()));
      else send_item(FuncTick, pick_mac(), pick_mac(), 4'($urandom()));
    end
  endtask

  // long receiver hold-off while the sender keeps offering, then a full drain and more random items
  task automatic test_backpressure();
    hold_cycles <= 60;
    @(posedge clk_i);
    test_random(20);
    wait_drained();
    test_random(10);
  endtask

  initial begin
    for (int i = 0; i < NumSlots; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_mac[i] = '0;
      tbl_port[i] = '0;
      tbl_stamp[i] = '0;
    end
    tick_count = '0;
    age_limit = MaxAgeReset;
    port_enables = PortsReset;
    for (int i = 0; i < 16; i++) mac_pool[i] = 48'({$urandom(), $urandom()});
    mac_pool[0] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    write_reg(2'(CfgMaxAge), 32'd6);
    write_reg(2'(CfgPorts), 32'hFFFF);
    test_random(250);
    send_idle_pct = 52;
    write_reg(2'(CfgPorts), 32'h7FFE);
    test_random(250);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    write_reg(2'(CfgMaxAge), 32'd20);
    test_random(250);
    send_idle_pct = 13;
    recv_stall_pct = 13;
    write_reg(2'(CfgPorts), 32'(16'hFFFF));
    test_random(200);
    recv_stall_pct = 0;
    send_idle_pct = 0;
    test_backpressure();

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("sent %0d items over frames, sweeps, removals and ticks; %0d results checked",
             items_sent, results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
